// ===== rtl/rmsp_pkg.sv =====
// Package for the RMSProp parameter update block: item types and register indexes.
// No dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none
package rmsp_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
  localparam logic [1:0] REG_DECAY       = 2'd1;
  localparam logic [1:0] REG_STAB_OFFSET = 2'd2;

  localparam logic [23:0] LEARN_RATE_RST  = 24'd16777;
  localparam logic [15:0] DECAY_RST       = 16'd58982;
  localparam logic [15:0] STAB_OFFSET_RST = 16'd1;

  localparam logic [47:0] SQ_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [11:0]        elem_index;
    logic signed [31:0] grad_in;
    logic signed [31:0] weight_in;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        index_out;
    logic signed [31:0] weight_out;
    logic               sat_flag;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/rmsprop_param_update_top.sv =====
// RMSProp per-element update: mean-square store, pipelined square root and divider.
// Depends on rmsp_pkg.
// Throughput one item per cycle, except while an item waits as described below.
// Apart from the clearing pass, a new item waits only while an older item on the same store
// entry has not written back or while the whole pipeline stalls on a held result.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all NUM_ELEMS
// entries, one per cycle, during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module rmsprop_param_update_top #(
  parameter int NUM_ELEMS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rmsp_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rmsp_pkg::out_item_t    out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_data
);
  import rmsp_pkg::*;

  localparam int AW = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
  localparam int SQ_ST = 24;
  localparam int DV_ST = 48;

  // Reduce an element index to its store entry.
  function automatic logic [AW-1:0] slot_of(input logic [11:0] idx);
    logic [12:0] r;
    r = {1'b0, idx};
    for (int k = 11; k >= 0; k--) begin
      if ((longint'(NUM_ELEMS) << k) <= 64'd4095) begin
        if (64'(r) >= (longint'(NUM_ELEMS) << k)) r = r - 13'((longint'(NUM_ELEMS) << k));
      end
    end
    return AW'(r);
  endfunction

  // Configuration registers
  logic [23:0] learn_rate_r;
  logic [15:0] decay_r;
  logic [15:0] stab_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r  <= LEARN_RATE_RST;
      decay_r       <= DECAY_RST;
      stab_offset_r <= STAB_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARN_RATE:  learn_rate_r  <= cfg_data;
        REG_DECAY:       decay_r       <= cfg_data[15:0];
        REG_STAB_OFFSET: stab_offset_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic [AW:0] clr_cnt_r;
  logic        clearing;
  assign clearing = (32'(clr_cnt_r) < NUM_ELEMS);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // Whole pipeline advances when the output register can take an item.
  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_ready;

  // Input decode
  logic [AW-1:0] slot_in;
  logic          gneg_in;
  logic [31:0]   gmag_in;
  logic [63:0]   g2_full;
  logic [47:0]   g2_in;
  logic          hazard;

  logic          v1_r, v2_r;
  logic [AW-1:0] slot1_r, slot2_r;

  assign slot_in = slot_of(in_data.elem_index);
  assign gneg_in = in_data.grad_in[31];
  assign gmag_in = gneg_in ? (~in_data.grad_in + 32'd1) : in_data.grad_in;
  assign g2_full = 64'(gmag_in) * 64'(gmag_in);
  assign g2_in   = (g2_full > 64'(SQ_MAX)) ? SQ_MAX : g2_full[47:0];
  assign hazard  = (v1_r && slot1_r == slot_in) || (v2_r && slot2_r == slot_in);
  assign in_ready = en && !clearing && !hazard;

  logic acc;
  assign acc = in_valid && in_ready;

  // Mean-square store: read on acceptance, written back from stage 2.
  logic [47:0] ms_mem [NUM_ELEMS];
  logic [47:0] rd_r;
  logic [47:0] s_new;

  always_ff @(posedge clk) begin
    if (clearing) ms_mem[clr_cnt_r[AW-1:0]] <= '0;
    else if (en && v2_r) ms_mem[slot2_r] <= s_new;
    if (en) rd_r <= ms_mem[slot_in];
  end

  // Stage 1 and 2 payload
  logic [11:0]  idx1_r, idx2_r;
  logic         gneg1_r, gneg2_r;
  logic [31:0]  w1_r, w2_r;
  logic [31:0]  gmag1_r;
  logic [47:0]  g2_1_r;
  logic [63:0]  pa2_r;
  logic [64:0]  pb2_r;
  logic [55:0]  num2_r;
  logic [65:0]  s_sum;

  assign s_sum = 66'(pa2_r) + 66'(pb2_r);
  assign s_new = (s_sum[65:16] > 50'(SQ_MAX)) ? SQ_MAX : s_sum[63:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot1_r <= slot_in;
      idx1_r  <= in_data.elem_index;
      gneg1_r <= gneg_in;
      w1_r    <= in_data.weight_in;
      gmag1_r <= gmag_in;
      g2_1_r  <= g2_in;
      slot2_r <= slot1_r;
      idx2_r  <= idx1_r;
      gneg2_r <= gneg1_r;
      w2_r    <= w1_r;
      pa2_r   <= 64'(decay_r) * 64'(rd_r);
      pb2_r   <= 65'(17'(32'd65536 - 32'(decay_r))) * 65'(g2_1_r);
      num2_r  <= 56'(learn_rate_r) * 56'(gmag1_r);
    end
  end

  // Square root pipeline, one root bit per stage.
  logic        sq_v_r   [SQ_ST];
  logic [11:0] sq_idx_r [SQ_ST];
  logic        sq_neg_r [SQ_ST];
  logic [31:0] sq_w_r   [SQ_ST];
  logic [47:0] sq_num_r [SQ_ST];
  logic [47:0] sq_val_r [SQ_ST];
  logic [26:0] sq_rem_r [SQ_ST];
  logic [23:0] sq_root_r[SQ_ST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_ST; i++) sq_v_r[i] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v2_r;
      for (int i = 1; i < SQ_ST; i++) sq_v_r[i] <= sq_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [26:0] rem;
    logic [26:0] trial;
    if (en) begin
      for (int i = 0; i < SQ_ST; i++) begin
        if (i == 0) begin
          rem   = {25'd0, s_new[47:46]};
          trial = 27'd1;
          sq_idx_r[0] <= idx2_r;
          sq_neg_r[0] <= gneg2_r;
          sq_w_r[0]   <= w2_r;
          sq_num_r[0] <= num2_r[55:8];
          sq_val_r[0] <= {s_new[45:0], 2'b00};
          if (rem >= trial) begin
            sq_rem_r[0]  <= rem - trial;
            sq_root_r[0] <= 24'd1;
          end else begin
            sq_rem_r[0]  <= rem;
            sq_root_r[0] <= 24'd0;
          end
        end else begin
          rem   = {sq_rem_r[i-1][24:0], sq_val_r[i-1][47:46]};
          trial = {1'b0, sq_root_r[i-1], 2'b01};
          sq_idx_r[i] <= sq_idx_r[i-1];
          sq_neg_r[i] <= sq_neg_r[i-1];
          sq_w_r[i]   <= sq_w_r[i-1];
          sq_num_r[i] <= sq_num_r[i-1];
          sq_val_r[i] <= {sq_val_r[i-1][45:0], 2'b00};
          if (rem >= trial) begin
            sq_rem_r[i]  <= rem - trial;
            sq_root_r[i] <= {sq_root_r[i-1][22:0], 1'b1};
          end else begin
            sq_rem_r[i]  <= rem;
            sq_root_r[i] <= {sq_root_r[i-1][22:0], 1'b0};
          end
        end
      end
    end
  end

  // Denominator: root plus offset, never zero.
  logic [24:0] d_sum;
  assign d_sum = 25'(sq_root_r[SQ_ST-1]) + 25'(stab_offset_r);

  // Restoring divider pipeline, one quotient bit per stage.
  logic        dv_v_r   [DV_ST+1];
  logic [11:0] dv_idx_r [DV_ST+1];
  logic        dv_neg_r [DV_ST+1];
  logic [31:0] dv_w_r   [DV_ST+1];
  logic [47:0] dv_num_r [DV_ST+1];
  logic [24:0] dv_d_r   [DV_ST+1];
  logic [25:0] dv_rem_r [DV_ST+1];
  logic [47:0] dv_q_r   [DV_ST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DV_ST; i++) dv_v_r[i] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_ST-1];
      for (int i = 1; i <= DV_ST; i++) dv_v_r[i] <= dv_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [25:0] rem;
    if (en) begin
      dv_idx_r[0] <= sq_idx_r[SQ_ST-1];
      dv_neg_r[0] <= sq_neg_r[SQ_ST-1];
      dv_w_r[0]   <= sq_w_r[SQ_ST-1];
      dv_num_r[0] <= sq_num_r[SQ_ST-1];
      dv_d_r[0]   <= (d_sum == 25'd0) ? 25'd1 : d_sum;
      dv_rem_r[0] <= '0;
      dv_q_r[0]   <= '0;
      for (int i = 1; i <= DV_ST; i++) begin
        rem = {dv_rem_r[i-1][24:0], dv_num_r[i-1][47]};
        dv_idx_r[i] <= dv_idx_r[i-1];
        dv_neg_r[i] <= dv_neg_r[i-1];
        dv_w_r[i]   <= dv_w_r[i-1];
        dv_num_r[i] <= {dv_num_r[i-1][46:0], 1'b0};
        dv_d_r[i]   <= dv_d_r[i-1];
        if (rem >= {1'b0, dv_d_r[i-1]}) begin
          dv_rem_r[i] <= rem - {1'b0, dv_d_r[i-1]};
          dv_q_r[i]   <= {dv_q_r[i-1][46:0], 1'b1};
        end else begin
          dv_rem_r[i] <= rem;
          dv_q_r[i]   <= {dv_q_r[i-1][46:0], 1'b0};
        end
      end
    end
  end

  // Apply the step and saturate into the output register.
  logic signed [49:0] wn;
  logic signed [49:0] w_ext;
  logic signed [49:0] step_ext;
  out_item_t          out_data_r;

  assign w_ext    = 50'(signed'(dv_w_r[DV_ST]));
  assign step_ext = signed'({2'b00, dv_q_r[DV_ST]});
  assign wn       = dv_neg_r[DV_ST] ? (w_ext + step_ext) : (w_ext - step_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_v_r[DV_ST];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.index_out <= dv_idx_r[DV_ST];
      if (wn > 50'sd2147483647) begin
        out_data_r.weight_out <= 32'h7FFF_FFFF;
        out_data_r.sat_flag   <= 1'b1;
      end else if (wn < -50'sd2147483648) begin
        out_data_r.weight_out <= 32'h8000_0000;
        out_data_r.sat_flag   <= 1'b1;
      end else begin
        out_data_r.weight_out <= wn[31:0];
        out_data_r.sat_flag   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/rmsp_port_checker.sv =====
// Port-level checks for the RMSProp update block, bound to the top level.
// Depends on rmsp_pkg and rmsprop_param_update_top.
`timescale 1ns / 1ps
`default_nettype none
module rmsp_port_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire rmsp_pkg::out_item_t out_data,
  input wire logic                cfg_ready
);
  import rmsp_pkg::*;

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A waiting result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // The clearing pass holds off input right after reset.
  a_clear: assert property (@(posedge clk) $past(!rst_n) && rst_n |-> !in_ready)
    else $error("input accepted during clearing pass");

  // No result can appear in the cycle after reset.
  a_no_early: assert property (@(posedge clk) $past(!rst_n) && rst_n |-> !out_valid)
    else $error("result item straight after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind rmsprop_param_update_top rmsp_port_checker u_rmsp_port_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the RMSProp parameter update block.
// Depends on rmsp_pkg and rmsprop_param_update_top; drives items, predicts each result and checks it.
`timescale 1ns / 1ps
module testbench;
  import rmsp_pkg::*;

  localparam int NUM_ELEMS = 4096;
  localparam int LATENCY   = 75;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  rmsprop_param_update_top #(.NUM_ELEMS(NUM_ELEMS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: mean-square store and register copies.
  logic [47:0] ms_store [NUM_ELEMS];
  logic [23:0] alpha_q;
  logic [15:0] beta_q;
  logic [15:0] eps_q;

  in_item_t    pending_items[$];
  out_item_t   expected_updates[$];
  int unsigned mismatch_count = 0;
  bit          idle_enable = 1'b1;
  bit          hold_sender = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  function automatic logic [47:0] root_of(input logic [47:0] v);
    logic [47:0] res;
    logic [47:0] rem;
    logic [47:0] b;
    res = '0;
    rem = v;
    b = 48'd1 << 46;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Works out the updated weight and advances the store entry.
  function automatic out_item_t rmsprop_update(input in_item_t it);
    out_item_t   r;
    logic [31:0] gmag;
    logic [63:0] g2;
    logic [80:0] acc;
    logic [47:0] s;
    logic [63:0] den;
    logic [63:0] stp;
    logic signed [65:0] wn;
    logic [11:0] slot;
    bit          gneg;
    gneg = it.grad_in[31];
    gmag = gneg ? (~it.grad_in + 32'd1) : it.grad_in;
    g2 = {32'd0, gmag} * {32'd0, gmag};
    if (g2 > {16'd0, SQ_MAX}) g2 = {16'd0, SQ_MAX};
    slot = 12'(it.elem_index % NUM_ELEMS);
    acc = 81'(beta_q) * 81'(ms_store[slot]) + 81'(17'd65536 - beta_q) * 81'(g2);
    acc = acc >> 16;
    s = (acc > 81'(SQ_MAX)) ? SQ_MAX : acc[47:0];
    ms_store[slot] = s;
    den = 64'(root_of(s)) + 64'(eps_q);
    if (den == 0) den = 64'd1;
    stp = (64'(alpha_q) * 64'(gmag)) / (den << 8);
    wn = gneg ? 66'(it.weight_in) + $signed({2'b00, stp})
              : 66'(it.weight_in) - $signed({2'b00, stp});
    r.index_out = it.elem_index;
    r.sat_flag = 1'b0;
    if (wn > 66'sd2147483647) begin
      r.weight_out = 32'sh7FFF_FFFF;
      r.sat_flag = 1'b1;
    end else if (wn < -66'sd2147483648) begin
      r.weight_out = 32'sh8000_0000;
      r.sat_flag = 1'b1;
    end else begin
      r.weight_out = wn[31:0];
    end
    return r;
  endfunction

  // Driver: presents queued items and predicts each on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_updates.push_back(rmsprop_update(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          if (idle_enable && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(0, 16);
            in_valid <= 1'b0;
          end else begin
            in_data <= pending_items.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results, stalls at random and compares field by field.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected item: %p", out_data);
        end else begin
          out_item_t e;
          e = expected_updates.pop_front();
          if (e.index_out !== out_data.index_out || e.weight_out !== out_data.weight_out ||
              e.sat_flag !== out_data.sat_flag) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected idx %0d w %0d sat %0b, got idx %0d w %0d sat %0b",
                       e.index_out, e.weight_out, e.sat_flag, out_data.index_out,
                       out_data.weight_out, out_data.sat_flag);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEARN_RATE:  alpha_q = val;
      REG_DECAY:       beta_q  = val[15:0];
      REG_STAB_OFFSET: eps_q   = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until the queue is empty and every expected item is back, then lets the pipe drain.
  task automatic drain_all();
    while (pending_items.size() > 0 || in_valid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [11:0] idx, input logic [31:0] g,
                                         input logic [31:0] w);
    in_item_t it;
    it.elem_index = idx;
    it.grad_in = g;
    it.weight_in = w;
    return it;
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 65536 * 4)) - 131072);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FF00 + $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [11:0] base;
    base = 12'($urandom);
    repeat (n) begin
      // Mostly revisit a small window of entries so the running mean builds up.
      if ($urandom_range(0, 3) != 0)
        pending_items.push_back(make_item(12'(base + $urandom_range(0, 7)), rand_grad(),
                                          rand_weight()));
      else
        pending_items.push_back(make_item(12'($urandom), rand_grad(), rand_weight()));
    end
  endtask

  // Stimulus sequence.
  initial begin
    foreach (ms_store[i]) ms_store[i] = '0;
    alpha_q = LEARN_RATE_RST;
    beta_q  = DECAY_RST;
    eps_q   = STAB_OFFSET_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at reset settings: field extremes, same entry back to back.
    pending_items.push_back(make_item(12'd0, 32'd0, 32'd0));
    pending_items.push_back(make_item(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(make_item(12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(12'd1, 32'h0001_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(12'd1, 32'hFFFF_0000, 32'h8000_0000));
    pending_items.push_back(make_item(12'd1, 32'h0000_0001, 32'h0000_0000));
    pending_items.push_back(make_item(12'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_items.push_back(make_item(12'h555, 32'hAAAA_AAAA, 32'h5555_5555));
    drain_all();

    // Largest step size, no averaging, zero epsilon; unknown register ignored.
    write_reg(REG_LEARN_RATE, 24'hFF_FFFF);
    write_reg(REG_DECAY, 24'd0);
    write_reg(REG_STAB_OFFSET, 24'd0);
    write_reg(REG_UNUSED, 24'h12_3456);
    pending_items.push_back(make_item(12'd3, 32'd0, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(12'd4, 32'h0000_0001, 32'h8000_0000));
    pending_items.push_back(make_item(12'd5, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(12'd6, 32'h8000_0000, 32'h7FFF_FF00));
    pending_items.push_back(make_item(12'd7, 32'h0000_0100, 32'h8000_0100));
    random_phase(150);
    // Part way through, the sender holds off until every expected result is back.
    while (pending_items.size() > 75) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || expected_updates.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain_all();
    pending_items.push_back(make_item(12'd7, 32'h0000_0100, 32'h0000_0000));
    random_phase(100);
    drain_all();

    // Largest decay, largest epsilon, zero step size.
    write_reg(REG_DECAY, 24'hFFFF);
    write_reg(REG_STAB_OFFSET, 24'hFFFF);
    write_reg(REG_LEARN_RATE, 24'd0);
    random_phase(150);
    drain_all();

    // Moderate settings.
    write_reg(REG_LEARN_RATE, 24'd65536);
    write_reg(REG_DECAY, 24'd32768);
    write_reg(REG_STAB_OFFSET, 24'd1);
    random_phase(200);
    drain_all();

    // Random settings, then a final stretch without idling.
    write_reg(REG_LEARN_RATE, 24'($urandom));
    write_reg(REG_DECAY, 24'($urandom));
    write_reg(REG_STAB_OFFSET, 24'($urandom_range(0, 65535)));
    random_phase(150);
    drain_all();
    idle_enable = 1'b0;
    random_phase(150);
    drain_all();

    if (mismatch_count == 0 && expected_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rmsp_pkg.sv
rtl/rmsprop_param_update_top.sv
rtl/rmsp_port_checker.sv
tb/testbench.sv
